// ===== rtl/core/conductivity_pot_trim_loop_macros.svh =====
// Assertion macros used by the conductivity pot trim loop checker.
// Plain text macros, no dependencies.
`ifndef CONDUCTIVITY_POT_TRIM_LOOP_MACROS_SVH
`define CONDUCTIVITY_POT_TRIM_LOOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cptl check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cptl check failed");

`endif

// ===== rtl/core/cptl_pkg.sv =====
// Types, constants and helpers for the conductivity pot trim loop.
// No dependencies; imported by every module of the block.
package cptl_pkg;

	localparam int MV_W       = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int POT_OUT_W  = 10;
	localparam int OUT_W      = 24;
	localparam int QUEUE_DEPTH = 2;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POT_INITIAL = 3'd4;

	// Reset values of the registers
	localparam logic [MV_W-1:0] WINDOW_LOW_RST  = 12'd1800;
	localparam logic [MV_W-1:0] WINDOW_HIGH_RST = 12'd2200;
	localparam logic [MV_W-1:0] BAND_HIGH_RST   = 12'd2005;
	localparam logic [MV_W-1:0] BAND_LOW_RST    = 12'd1995;
	localparam int POT_INITIAL_RST = 327;

	localparam logic [MV_W-1:0] MV_MAX = 12'd4095;

	// Sample to millivolts: floor(sample * 803 / 1000), saturated at 4095.
	// The division is (x >> 3) / 125 by reciprocal; exact for y < 512000.
	localparam int MV_GAIN      = 803;
	localparam int MV_GAIN_W    = 10;
	localparam int MV_SAT_PROD  = 4096000;
	localparam int MV_SAT_W     = 22;
	localparam int DIV125_Y_W   = 19;
	localparam int DIV125_MUL   = 536871;
	localparam int DIV125_SHIFT = 26;
	localparam int DIV125_P_W   = 39;

	// Running average: (ra*19 + mv) / 20 = ((sum >> 2) * 52429) >> 18
	localparam int SUM19_W     = 17;
	localparam int DIV5_IN_W   = 15;
	localparam int DIV5_MUL    = 52429;
	localparam int DIV5_SHIFT  = 18;
	localparam int DIV5_P_W    = 31;

	// Blend: (ra*2 + mv) / 3 = (w * 21846) >> 16
	localparam int BLEND_W     = 14;
	localparam int DIV3_MUL    = 21846;
	localparam int DIV3_SHIFT  = 16;
	localparam int DIV3_P_W    = 29;

	typedef logic [MV_W-1:0] mv_t;

	typedef enum logic {
		EV_INIT = 1'b0,
		EV_TICK = 1'b1
	} ev_kind_t;

	typedef struct packed {
		mv_t window_low;
		mv_t window_high;
		mv_t band_high;
		mv_t band_low;
	} cfg_t;

	typedef struct packed {
		ev_kind_t kind;
		logic     init_ok;
		mv_t      mv;
	} q_item_t;

	typedef struct packed {
		logic                 en;
		logic [POT_OUT_W-1:0] value;
	} pot_load_t;

	function automatic logic in_window(input mv_t v, input cfg_t cfg);
		return (v > cfg.window_low) && (v < cfg.window_high);
	endfunction

endpackage

// ===== rtl/core/cptl_front.sv =====
// Front end of the trim loop: takes events, checks init samples against the
// window and converts samples to millivolts. Depends on cptl_pkg.
module cptl_front #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cptl_pkg::ev_kind_t  in_kind,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  cptl_pkg::cfg_t      cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output cptl_pkg::q_item_t   out_item
);
	import cptl_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + MV_GAIN_W;
	localparam int SAT_W  = (PROD_W > MV_SAT_W) ? PROD_W : MV_SAT_W;
	localparam int FIVE_W = (SAMPLE_BITS + 3 > MV_W) ? SAMPLE_BITS + 3 : MV_W;

	logic              valid_s1, valid_s2;
	logic              s1_ready, s2_ready;
	ev_kind_t          kind_s1;
	logic              init_ok_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [FIVE_W-1:0] five_x;
	logic              init_ok;
	logic [SAT_W-1:0]  prod_ext;
	logic [DIV125_Y_W-1:0] div_y;
	logic [DIV125_P_W-1:0] div_p;
	mv_t               mv;

	assign s2_ready = !valid_s2 || out_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign in_ready = s1_ready;

	always_comb begin
		five_x  = FIVE_W'({in_sample, 2'b00}) + FIVE_W'(in_sample);
		init_ok = (five_x > FIVE_W'(cfg.window_low)) && (five_x < FIVE_W'(cfg.window_high));
	end

	always_comb begin
		prod_ext = SAT_W'(prod_s1);
		div_y    = prod_ext[3 +: DIV125_Y_W];
		div_p    = DIV125_P_W'(div_y) * DIV125_P_W'(DIV125_MUL);
		if (prod_ext >= SAT_W'(MV_SAT_PROD)) begin
			mv = MV_MAX;
		end else begin
			mv = div_p[DIV125_SHIFT +: MV_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_ready) begin
			kind_s1    <= in_kind;
			init_ok_s1 <= init_ok;
			prod_s1    <= PROD_W'(in_sample) * PROD_W'(MV_GAIN);
		end
		if (valid_s1 && s2_ready) begin
			out_item.kind    <= kind_s1;
			out_item.init_ok <= init_ok_s1;
			out_item.mv      <= mv;
		end
	end

	assign out_valid = valid_s2;

endmodule

// ===== rtl/core/cptl_queue.sv =====
// Short queue between the front end and the control back end.
// Depends on cptl_pkg for the queued item type.
module cptl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  cptl_pkg::q_item_t push_item,
	output logic              pop_valid,
	input  logic              pop_ready,
	output cptl_pkg::q_item_t pop_item
);
	import cptl_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_item_t           slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/cptl_back.sv =====
// Back end of the trim loop: mode, running average, blend and pot stepping,
// in two pipeline stages ending in the result register. Depends on cptl_pkg.
module cptl_back #(
	parameter int POT_STEPS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  cptl_pkg::q_item_t                in_item,
	input  cptl_pkg::cfg_t                   cfg,
	input  cptl_pkg::pot_load_t              pot_load,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             status,
	output logic                             pot_write,
	output logic [cptl_pkg::POT_OUT_W-1:0]   pot_value,
	output cptl_pkg::mv_t                    average_mv
);
	import cptl_pkg::*;

	localparam int PW = $clog2(POT_STEPS);
	localparam int CW = (PW > POT_OUT_W) ? PW : POT_OUT_W;
	localparam int POT_RST_I = (POT_INITIAL_RST > POT_STEPS - 1) ? POT_STEPS - 1
		: POT_INITIAL_RST;
	localparam logic [PW-1:0] POT_MAX_V = PW'(POT_STEPS - 1);
	localparam logic [PW-1:0] POT_RST_V = PW'(POT_RST_I);

	// Loop state. The blended average is recomputed before every use, so
	// only the running average is kept.
	logic          active_q;
	mv_t           ra_q;
	logic [PW-1:0] pot_q;

	logic valid_s1, valid_s2, s2_ready, take_s1, take_s2;
	logic status_s1, write_s1, trim_s1;
	mv_t  ra_s1, mv_s1;
	logic status_s2, write_s2;
	mv_t  avg_s2;

	logic [SUM19_W-1:0]  ra_sum;
	logic [DIV5_P_W-1:0] div5_p;
	mv_t                 ra_upd;
	logic nxt_status, nxt_write, nxt_trim, nxt_active;
	mv_t  nxt_ra;

	logic [BLEND_W-1:0]  blend_w;
	logic [DIV3_P_W-1:0] div3_p;
	mv_t                 blend;
	logic                step_write;
	logic [PW-1:0]       pot_nxt;
	logic [CW-1:0]       load_ext;
	logic [PW-1:0]       load_val;

	assign s2_ready = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || s2_ready;
	assign take_s1  = in_valid && in_ready;
	assign take_s2  = valid_s1 && s2_ready;

	// Stage 1: mode handling and the 19/20 running average
	always_comb begin
		ra_sum = SUM19_W'({ra_q, 4'b0000}) + SUM19_W'({ra_q, 1'b0}) + SUM19_W'(ra_q)
			+ SUM19_W'(in_item.mv);
		div5_p = DIV5_P_W'(ra_sum[2 +: DIV5_IN_W]) * DIV5_P_W'(DIV5_MUL);
		ra_upd = div5_p[DIV5_SHIFT +: MV_W];

		nxt_status = 1'b0;
		nxt_write  = 1'b0;
		nxt_trim   = 1'b0;
		nxt_active = active_q;
		nxt_ra     = ra_q;
		if (!active_q) begin
			if (in_item.kind == EV_INIT) begin
				nxt_write  = 1'b1;
				nxt_status = !in_item.init_ok;
			end else begin
				nxt_ra     = in_item.mv;
				nxt_active = 1'b1;
				nxt_write  = !in_window(in_item.mv, cfg);
			end
		end else if (in_item.kind == EV_TICK) begin
			if (in_window(ra_q, cfg)) begin
				nxt_ra   = ra_upd;
				nxt_trim = 1'b1;
			end else begin
				nxt_status = 1'b1;
			end
		end
	end

	// Stage 2: 2/3 blend and pot stepping with saturation
	always_comb begin
		blend_w    = BLEND_W'({ra_s1, 1'b0}) + BLEND_W'(mv_s1);
		div3_p     = DIV3_P_W'(blend_w) * DIV3_P_W'(DIV3_MUL);
		blend      = div3_p[DIV3_SHIFT +: MV_W];
		step_write = 1'b0;
		pot_nxt    = pot_q;
		if (trim_s1) begin
			if (blend > cfg.band_high) begin
				step_write = 1'b1;
				if (pot_q != '0) begin
					pot_nxt = pot_q - PW'(1);
				end
			end else if (blend < cfg.band_low) begin
				step_write = 1'b1;
				if (pot_q != POT_MAX_V) begin
					pot_nxt = pot_q + PW'(1);
				end
			end
		end
	end

	always_comb begin
		load_ext = CW'(pot_load.value);
		if (load_ext > CW'(POT_STEPS - 1)) begin
			load_val = POT_MAX_V;
		end else begin
			load_val = PW'(load_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			active_q <= 1'b0;
			ra_q     <= '0;
			pot_q    <= POT_RST_V;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (take_s1) begin
				active_q <= nxt_active;
				ra_q     <= nxt_ra;
			end
			if (pot_load.en) begin
				pot_q <= load_val;
			end else if (take_s2) begin
				pot_q <= pot_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			status_s1 <= nxt_status;
			write_s1  <= nxt_write;
			trim_s1   <= nxt_trim;
			ra_s1     <= nxt_ra;
			mv_s1     <= in_item.mv;
		end
		if (take_s2) begin
			status_s2 <= status_s1;
			write_s2  <= write_s1 || step_write;
			avg_s2    <= ra_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign status     = status_s2;
	assign pot_write  = write_s2;
	assign pot_value  = POT_OUT_W'(pot_q);
	assign average_mv = avg_s2;

endmodule

// ===== rtl/core/conductivity_pot_trim_loop.sv =====
// Conductivity potentiometer trim loop, top level.
// Instantiates cptl_front, cptl_queue and cptl_back; depends on cptl_pkg.
//
// Usage:
//   s_* channel: one event per transfer. s_tuser carries the event kind
//   (init check or one-second tick), s_tdata the raw ADC sample.
//   m_* channel: one result per event: status, pot write strobe, pot setting
//   and running average in millivolts, packed into m_tdata.
//   cfg_* channel: register writes (window limits, deadband, initial pot).
//   cfg_ready is always high; write only while no event is in flight.
//   Writing the initial pot register also loads the pot setting at once.
// Path: an s_* transfer passes the two front stages (the constant-multiply
//   conversion), a queue slot and the two back stages before m_tvalid.
// Throughput: one event per cycle while m_tready is high. The recurrence on
//   the running average closes in back stage 1 and the pot step in back stage 2.
// Reset: arst_n clears all stages and the queue, the loop goes idle, the
//   running average goes to zero and the pot setting to the initial pot value.
// Stall: when m_tready is low the result register holds; the back end then
//   stops, the two-entry queue fills, and s_tready drops only once the front
//   stages are full as well.
module conductivity_pot_trim_loop #(
	parameter int SAMPLE_BITS = 12,
	parameter int POT_STEPS   = 1024
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Event input
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // [SAMPLE_BITS-1:0] sample
	input  logic [0:0]                              s_tuser,  // [0] func
	// Result output
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [cptl_pkg::OUT_W-1:0]              m_tdata,  // [0] status, [1] pot_write,
	                                                          // [11:2] pot_value,
	                                                          // [23:12] average_mv
	// Configuration writes
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [cptl_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [cptl_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import cptl_pkg::*;

	cfg_t      cfg_q;
	pot_load_t pot_load;
	logic      cfg_xfer;

	logic      fq_valid, fq_ready;
	q_item_t   fq_item;
	logic      qb_valid, qb_ready;
	q_item_t   qb_item;

	logic                 res_status, res_write;
	logic [POT_OUT_W-1:0] res_pot;
	mv_t                  res_avg;

	// Configuration registers; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_low  <= WINDOW_LOW_RST;
			cfg_q.window_high <= WINDOW_HIGH_RST;
			cfg_q.band_high   <= BAND_HIGH_RST;
			cfg_q.band_low    <= BAND_LOW_RST;
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				CFG_WINDOW_LOW:  cfg_q.window_low  <= cfg_data;
				CFG_WINDOW_HIGH: cfg_q.window_high <= cfg_data;
				CFG_BAND_HIGH:   cfg_q.band_high   <= cfg_data;
				CFG_BAND_LOW:    cfg_q.band_low    <= cfg_data;
				default: ;
			endcase
		end
	end

	// The initial pot value is only ever used to load the pot setting,
	// so pass the write straight to the back end
	assign pot_load.en    = cfg_xfer && (cfg_index == CFG_POT_INITIAL);
	assign pot_load.value = cfg_data[POT_OUT_W-1:0];

	cptl_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (ev_kind_t'(s_tuser[0])),
		.in_sample (s_tdata[SAMPLE_BITS-1:0]),
		.cfg       (cfg_q),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_item  (fq_item)
	);

	cptl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item)
	);

	cptl_back #(
		.POT_STEPS(POT_STEPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (qb_valid),
		.in_ready   (qb_ready),
		.in_item    (qb_item),
		.cfg        (cfg_q),
		.pot_load   (pot_load),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.status     (res_status),
		.pot_write  (res_write),
		.pot_value  (res_pot),
		.average_mv (res_avg)
	);

	assign m_tdata = {res_avg, res_pot, res_write, res_status};

endmodule

// ===== rtl/core/cptl_checker.sv =====
// Port-level checks for the conductivity pot trim loop, bound to the top.
// Depends on cptl_pkg and conductivity_pot_trim_loop_macros.svh.
`include "conductivity_pot_trim_loop_macros.svh"

module cptl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [cptl_pkg::OUT_W-1:0]     m_tdata,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [cptl_pkg::CFG_IDX_W-1:0] cfg_index
);
	import cptl_pkg::*;

	logic [3:0]           outstanding_q;
	logic [POT_OUT_W-1:0] last_pot_q;
	logic                 last_valid_q;
	logic                 in_xfer, out_xfer;
	logic                 out_write;
	logic [POT_OUT_W-1:0] out_pot;

	assign in_xfer   = s_tvalid && s_tready;
	assign out_xfer  = m_tvalid && m_tready;
	assign out_write = m_tdata[1];
	assign out_pot   = m_tdata[2 +: POT_OUT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
			last_valid_q  <= 1'b0;
		end else begin
			if (in_xfer && !out_xfer) begin
				outstanding_q <= outstanding_q + 4'd1;
			end else if (out_xfer && !in_xfer) begin
				outstanding_q <= outstanding_q - 4'd1;
			end
			if (cfg_valid && cfg_ready && (cfg_index == CFG_POT_INITIAL)) begin
				last_valid_q <= 1'b0;
			end else if (out_xfer) begin
				last_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_xfer) begin
			last_pot_q <= out_pot;
		end
	end

	`CPTL_ASSERT_NEXT(a_result_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`CPTL_ASSERT_IMP(a_cfg_always_ready, clk, arst_n, cfg_valid, cfg_ready)
	`CPTL_ASSERT_IMP(a_no_extra_result, clk, arst_n, out_xfer, outstanding_q != 4'd0)
	`CPTL_ASSERT_IMP(a_pot_held, clk, arst_n, out_xfer && !out_write && last_valid_q, out_pot == last_pot_q)
	`CPTL_ASSERT_IMP(a_pot_single_step, clk, arst_n, out_xfer && out_write && last_valid_q, (out_pot == last_pot_q) || (out_pot == last_pot_q + POT_OUT_W'(1)) || (out_pot + POT_OUT_W'(1) == last_pot_q))

endmodule

bind conductivity_pot_trim_loop cptl_checker u_cptl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index)
);
